// File: sv/rrts_pkg.sv
// shared constants, codes and control/status types of the thread scheduler
package rrts_pkg;

	// number of thread slots and the width of a slot number
	localparam int THREADS = 16;
	localparam int SLOT_W  = (THREADS > 1) ? $clog2(THREADS) : 1;

	typedef logic [SLOT_W-1:0] slot_t;

	// slot states
	localparam logic [1:0] ST_DEAD     = 2'd0;
	localparam logic [1:0] ST_RUNNABLE = 2'd1;
	localparam logic [1:0] ST_RUNNING  = 2'd2;
	localparam logic [1:0] ST_BLOCKED  = 2'd3;

	// commands
	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_EXIT   = 2'd1;
	localparam logic [1:0] CMD_JOIN   = 2'd2;
	localparam logic [1:0] CMD_YIELD  = 2'd3;

	// result status codes
	localparam logic [1:0] RES_OK            = 2'd0;
	localparam logic [1:0] RES_NO_SLOT       = 2'd1;
	localparam logic [1:0] RES_TARGET_DEAD   = 2'd2;
	localparam logic [1:0] RES_NONE_RUNNABLE = 2'd3;

	// table address select
	localparam logic [1:0] ADDR_SCAN = 2'd0;
	localparam logic [1:0] ADDR_CUR  = 2'd1;
	localparam logic [1:0] ADDR_TGT  = 2'd2;
	localparam logic [1:0] ADDR_JNR  = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic [1:0] addr_sel;
		logic       st_we;
		logic [1:0] st_wdata;
		logic       jn_we;
		logic       jn_wvalid;
		logic       jn_latch;
		logic       wr_latch;
		logic       run_load;
		logic       created;
		logic       fin;
		logic [1:0] fin_status;
	} ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [1:0] rd_state;
		logic       k_last;
		logic       j_valid;
		logic       was_running;
		logic       tgt_ok;
		logic [1:0] cmd;
	} sts_t;

	// low four bits of a slot number, zero-extended when slots are narrower
	function automatic logic [3:0] slot_lo4(input slot_t s);
		logic [SLOT_W+3:0] t;
		t = {4'b0000, s};
		return t[3:0];
	endfunction

endpackage

// File: sv/rrts_ctrl.sv
// sequencing controller of the thread scheduler
module rrts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    cmd,
	output logic          busy,
	input  rrts_pkg::sts_t sts,
	output rrts_pkg::ctl_t ctl
);
	import rrts_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CR_SCAN  = 4'd1;
	localparam logic [3:0] S_EX_KILL  = 4'd2;
	localparam logic [3:0] S_EX_WAKE  = 4'd3;
	localparam logic [3:0] S_JN_CHECK = 4'd4;
	localparam logic [3:0] S_JN_BLOCK = 4'd5;
	localparam logic [3:0] S_YD_PREP  = 4'd6;
	localparam logic [3:0] S_SC_SCAN  = 4'd7;
	localparam logic [3:0] S_YD_BACK  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (cmd)
						CMD_CREATE: state_d = S_CR_SCAN;
						CMD_EXIT:   state_d = S_EX_KILL;
						CMD_JOIN:   state_d = S_JN_CHECK;
						CMD_YIELD:  state_d = S_YD_PREP;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CR_SCAN: begin
				ctl.addr_sel = ADDR_SCAN;
				if (sts.rd_state == ST_DEAD) begin
					ctl.st_we      = 1'b1;
					ctl.st_wdata   = ST_RUNNABLE;
					ctl.jn_we      = 1'b1;
					ctl.jn_wvalid  = 1'b0;
					ctl.created    = 1'b1;
					ctl.fin        = 1'b1;
					ctl.fin_status = RES_OK;
					state_d        = S_IDLE;
				end else if (sts.k_last) begin
					ctl.fin        = 1'b1;
					ctl.fin_status = RES_NO_SLOT;
					state_d        = S_IDLE;
				end
			end
			S_EX_KILL: begin
				ctl.addr_sel  = ADDR_CUR;
				ctl.st_we     = 1'b1;
				ctl.st_wdata  = ST_DEAD;
				ctl.jn_latch  = 1'b1;
				ctl.jn_we     = 1'b1;
				ctl.jn_wvalid = 1'b0;
				state_d       = S_EX_WAKE;
			end
			S_EX_WAKE: begin
				ctl.addr_sel = ADDR_JNR;
				ctl.st_we    = sts.j_valid;
				ctl.st_wdata = ST_RUNNABLE;
				state_d      = S_SC_SCAN;
			end
			S_JN_CHECK: begin
				ctl.addr_sel = ADDR_TGT;
				if (!sts.tgt_ok || sts.rd_state == ST_DEAD) begin
					ctl.fin        = 1'b1;
					ctl.fin_status = RES_TARGET_DEAD;
					state_d        = S_IDLE;
				end else begin
					ctl.jn_we     = 1'b1;
					ctl.jn_wvalid = 1'b1;
					state_d       = S_JN_BLOCK;
				end
			end
			S_JN_BLOCK: begin
				ctl.addr_sel = ADDR_CUR;
				ctl.st_we    = 1'b1;
				ctl.st_wdata = ST_BLOCKED;
				state_d      = S_SC_SCAN;
			end
			S_YD_PREP: begin
				ctl.addr_sel = ADDR_CUR;
				ctl.wr_latch = 1'b1;
				ctl.st_we    = (sts.rd_state == ST_RUNNING);
				ctl.st_wdata = ST_RUNNABLE;
				state_d      = S_SC_SCAN;
			end
			S_SC_SCAN: begin
				ctl.addr_sel = ADDR_SCAN;
				if (sts.rd_state == ST_RUNNABLE) begin
					ctl.st_we      = 1'b1;
					ctl.st_wdata   = ST_RUNNING;
					ctl.run_load   = 1'b1;
					ctl.fin        = 1'b1;
					ctl.fin_status = RES_OK;
					state_d        = S_IDLE;
				end else if (sts.k_last) begin
					if (sts.cmd == CMD_YIELD && sts.was_running) begin
						state_d = S_YD_BACK;
					end else begin
						ctl.fin        = 1'b1;
						ctl.fin_status = RES_NONE_RUNNABLE;
						state_d        = S_IDLE;
					end
				end
			end
			S_YD_BACK: begin
				ctl.addr_sel   = ADDR_CUR;
				ctl.st_we      = 1'b1;
				ctl.st_wdata   = ST_RUNNING;
				ctl.fin        = 1'b1;
				ctl.fin_status = RES_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/rrts_datapath.sv
// thread tables, scan counter and result registers of the thread scheduler
module rrts_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     cmd,
	input  logic [3:0]     target,
	input  rrts_pkg::ctl_t ctl,
	output rrts_pkg::sts_t sts,
	output logic           done,
	output logic [1:0]     status,
	output logic [3:0]     running,
	output logic [3:0]     new_thread,
	output logic           switched
);
	import rrts_pkg::*;

	localparam int TGT_W = SLOT_W + 4;

	logic [1:0]  slot_state_q [THREADS];
	logic        jn_valid_q   [THREADS];
	slot_t       jn_slot_q    [THREADS];

	slot_t       run_q;
	slot_t       k_q;
	logic [1:0]  cmd_q;
	logic [3:0]  target_q;
	logic        j_valid_q;
	slot_t       j_slot_q;
	logic        was_run_q;

	logic        done_q;
	logic [1:0]  status_q;
	logic [3:0]  new_thread_q;
	logic        switched_q;

	logic [SLOT_W:0] scan_sum;
	slot_t           scan_idx;
	logic [TGT_W-1:0] tgt_ext;
	slot_t           addr;
	logic [1:0]      rd_state;

	// round-robin position: running slot plus offset, wrapped at the slot count
	always_comb begin
		scan_sum = {1'b0, run_q} + {1'b0, k_q};
		if (scan_sum >= (SLOT_W+1)'(THREADS)) begin
			scan_idx = SLOT_W'(scan_sum - (SLOT_W+1)'(THREADS));
		end else begin
			scan_idx = scan_sum[SLOT_W-1:0];
		end
	end

	assign tgt_ext = TGT_W'(target_q);

	always_comb begin
		unique case (ctl.addr_sel)
			ADDR_SCAN: addr = scan_idx;
			ADDR_CUR:  addr = run_q;
			ADDR_TGT:  addr = tgt_ext[SLOT_W-1:0];
			ADDR_JNR:  addr = j_slot_q;
			default:   addr = run_q;
		endcase
	end

	assign rd_state = slot_state_q[addr];

	assign sts.rd_state    = rd_state;
	assign sts.k_last      = (k_q == SLOT_W'(THREADS - 1));
	assign sts.j_valid     = j_valid_q;
	assign sts.was_running = was_run_q;
	assign sts.tgt_ok      = (tgt_ext < TGT_W'(THREADS));
	assign sts.cmd         = cmd_q;

	// state table: slot zero running, others dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				slot_state_q[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
			end
		end else if (ctl.st_we) begin
			slot_state_q[addr] <= ctl.st_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				jn_valid_q[i] <= 1'b0;
			end
		end else if (ctl.jn_we) begin
			jn_valid_q[addr] <= ctl.jn_wvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.jn_we) begin
			jn_slot_q[addr] <= run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
			if (ctl.run_load) begin
				run_q <= scan_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			target_q <= target;
			k_q      <= SLOT_W'(1);
		end else if (ctl.addr_sel == ADDR_SCAN && !sts.k_last) begin
			k_q <= k_q + SLOT_W'(1);
		end
		if (ctl.jn_latch) begin
			j_valid_q <= jn_valid_q[addr];
			j_slot_q  <= jn_slot_q[addr];
		end
		if (ctl.wr_latch) begin
			was_run_q <= (rd_state == ST_RUNNING);
		end
		if (ctl.fin) begin
			status_q     <= ctl.fin_status;
			new_thread_q <= ctl.created ? slot_lo4(scan_idx) : 4'd0;
			switched_q   <= ctl.run_load;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign running    = slot_lo4(run_q);
	assign new_thread = new_thread_q;
	assign switched   = switched_q;

endmodule

// File: sv/round_robin_thread_scheduler_unit.sv
// top level of the round-robin thread scheduler: controller plus datapath
//
// Takes one command (create, exit, join, yield) per beat when start is high and busy is
// low, and answers with exactly one result beat: done is high for a single cycle with
// status, running, new_thread and switched valid in that cycle. There is no back-pressure
// on the result side, so done must be sampled whenever it rises. A failed join on a dead
// target is among the shortest commands and an exit with a full scan among the longest;
// how long a command takes is set by the round-robin scan, which steps through one slot
// of the state table per cycle. busy drops in the cycle that the result beat is shown, so
// a new command may be issued alongside it. After reset slot zero is running and every
// other slot is dead; no clearing pass is needed.
module round_robin_thread_scheduler_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [3:0] target,
	output logic       done,
	output logic [1:0] status,
	output logic [3:0] running,
	output logic [3:0] new_thread,
	output logic       switched
);
	import rrts_pkg::*;

	// command and status bundles between sequencer and datapath
	ctl_t ctl;
	sts_t sts;

	// sequencer: one state per table access, scan states loop over the slots
	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// datapath: state and joiner tables, running slot, scan offset, result registers
	rrts_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.target     (target),
		.ctl        (ctl),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.running    (running),
		.new_thread (new_thread),
		.switched   (switched)
	);

endmodule

// File: tb/sv/sched_checker.sv
// thread scheduler checker: predicts each command's result beat and compares the beats seen
module sched_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] cmd,
	input  logic [3:0] target,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [3:0] running,
	input  logic [3:0] new_thread,
	input  logic       switched,
	output int         errors,
	output int         pending
);
	import rrts_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] running;
		logic [3:0] new_thread;
		logic       switched;
	} sched_beat_t;

	// own copy of the thread table
	logic [1:0]  thread_st [THREADS];
	logic        jn_valid [THREADS];
	slot_t       jn_slot [THREADS];
	slot_t       cur_slot;

	sched_beat_t awaited_beats [$];
	sched_beat_t want_beat;
	sched_beat_t next_beat;
	int          i;

	// round-robin search after the running slot, never the running slot itself
	function automatic bit find_after(input logic [1:0] want, output slot_t found);
		int idx;
		found = '0;
		for (int k = 1; k < THREADS; k++) begin
			idx = (int'(cur_slot) + k) % THREADS;
			if (thread_st[idx] == want) begin
				found = slot_t'(idx);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit pick_next();
		slot_t s;
		if (!find_after(ST_RUNNABLE, s))
			return 1'b0;
		cur_slot = s;
		thread_st[s] = ST_RUNNING;
		return 1'b1;
	endfunction

	task automatic apply_command(input logic [1:0] c, input logic [3:0] t,
			output sched_beat_t r);
		slot_t found;
		slot_t prior;
		logic  was_run;
		prior = cur_slot;
		r = '0;
		r.status = RES_OK;
		case (c)
			CMD_CREATE: begin
				if (find_after(ST_DEAD, found)) begin
					thread_st[found] = ST_RUNNABLE;
					jn_valid[found] = 1'b0;
					jn_slot[found] = '0;
					r.new_thread = 4'(found);
				end else begin
					r.status = RES_NO_SLOT;
				end
			end
			CMD_EXIT: begin
				thread_st[cur_slot] = ST_DEAD;
				// a self-joined slot wakes itself here
				if (jn_valid[cur_slot]) begin
					thread_st[jn_slot[cur_slot]] = ST_RUNNABLE;
					jn_valid[cur_slot] = 1'b0;
					jn_slot[cur_slot] = '0;
				end
				if (!pick_next())
					r.status = RES_NONE_RUNNABLE;
			end
			CMD_JOIN: begin
				if (int'(t) >= THREADS || thread_st[t] == ST_DEAD) begin
					r.status = RES_TARGET_DEAD;
				end else begin
					thread_st[cur_slot] = ST_BLOCKED;
					jn_valid[t] = 1'b1;
					jn_slot[t] = cur_slot;
					if (!pick_next())
						r.status = RES_NONE_RUNNABLE;
				end
			end
			default: begin
				was_run = (thread_st[cur_slot] == ST_RUNNING);
				if (was_run)
					thread_st[cur_slot] = ST_RUNNABLE;
				if (!pick_next()) begin
					if (was_run)
						thread_st[cur_slot] = ST_RUNNING;
					else
						r.status = RES_NONE_RUNNABLE;
				end
			end
		endcase
		r.running = 4'(cur_slot);
		r.switched = (cur_slot != prior);
	endtask

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < THREADS; i++) begin
				thread_st[i] = (i == 0) ? ST_RUNNING : ST_DEAD;
				jn_valid[i] = 1'b0;
				jn_slot[i] = '0;
			end
			cur_slot = '0;
			awaited_beats.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// a result beat shown alongside the next accepted command is checked first
			if (done) begin
				if (awaited_beats.size() == 0) begin
					$display("%0t: result beat mismatch, expected none, %s %0d running %0d",
						$time, "actual status", status, running);
					errors++;
				end else begin
					want_beat = awaited_beats.pop_front();
					cmp_field("status", int'(want_beat.status), int'(status));
					cmp_field("running", int'(want_beat.running), int'(running));
					cmp_field("new_thread", int'(want_beat.new_thread), int'(new_thread));
					cmp_field("switched", int'(want_beat.switched), int'(switched));
				end
			end
			if (start && !busy) begin
				apply_command(cmd, target, next_beat);
				awaited_beats.push_back(next_beat);
			end
			pending <= awaited_beats.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// top of the thread scheduler testbench: clock, reset, command stimulus and verdict
module tb;
	import rrts_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] cmd = CMD_CREATE;
	logic [3:0] target = 4'd0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [3:0] running;
	logic [3:0] new_thread;
	logic       switched;
	int         errors;
	int         pending;

	// items of the random part, and the run of them sent with no gaps at all
	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_FIRST   = 300;
	localparam int CALM_LAST    = 500;
	// item before which the sender holds off until the scheduler has answered everything
	localparam int DRAIN_ITEM   = 650;

	always #2 clk = ~clk;

	round_robin_thread_scheduler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.target    (target),
		.done      (done),
		.status    (status),
		.running   (running),
		.new_thread(new_thread),
		.switched  (switched)
	);

	// the checker sees the same edges as the block and keeps the expected beats
	sched_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.target    (target),
		.done      (done),
		.status    (status),
		.running   (running),
		.new_thread(new_thread),
		.switched  (switched),
		.errors    (errors),
		.pending   (pending)
	);

	// about 14 commands in a hundred follow a gap; the longest gaps outlast the full scan,
	// so that the gap ends at every step of the scan
	function automatic int draw_gap();
		return ($urandom_range(0, 99) < 14) ? $urandom_range(1, 20) : 0;
	endfunction

	// present one command beat and hold it until the scheduler takes it;
	// start stays high when the next command follows with no gap, so it
	// never gets two assignments at one edge
	task automatic issue(input logic [1:0] c, input logic [3:0] t, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			// noise on the command lines while start is low
			cmd <= 2'($urandom_range(0, 3));
			target <= 4'($urandom_range(0, 15));
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		target <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// wait for the last expected beat; pending is registered, hence the first edge
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int mood;
		int roll;
		int p_create;
		int p_exit;
		int p_join;
		logic [1:0] c;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening: slot zero alone, yield keeps it running
		issue(CMD_YIELD, 4'($urandom_range(0, 15)), draw_gap());
		issue(CMD_CREATE, 4'($urandom_range(0, 15)), draw_gap());
		// zero waits on one, one runs
		issue(CMD_JOIN, 4'd1, draw_gap());
		// one joins itself: replaces zero as joiner and leaves nothing runnable
		issue(CMD_JOIN, 4'd1, draw_gap());
		// stalled slot: yield reports nothing runnable
		issue(CMD_YIELD, 4'($urandom_range(0, 15)), draw_gap());
		// exit from a stalled slot wakes itself as its own joiner, still nothing else to run
		issue(CMD_EXIT, 4'($urandom_range(0, 15)), draw_gap());
		issue(CMD_CREATE, 4'($urandom_range(0, 15)), draw_gap());
		// yield from a runnable but not running slot switches away
		issue(CMD_YIELD, 4'($urandom_range(0, 15)), draw_gap());
		// joins on dead slots, top slot number among them
		issue(CMD_JOIN, 4'd9, draw_gap());
		issue(CMD_JOIN, 4'd15, draw_gap());
		// fill the table, then one create too many
		repeat (14) issue(CMD_CREATE, 4'($urandom_range(0, 15)), draw_gap());
		// join on the highest slot, now live
		issue(CMD_JOIN, 4'd15, draw_gap());

		// random part: the mix drifts between filling, emptying and a balance, so the
		// table swings between full, empty and the stalled cases in between
		mood = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				mood = $urandom_range(0, 2);
			case (mood)
				0: begin p_create = 50; p_exit = 10; p_join = 15; end
				1: begin p_create = 10; p_exit = 45; p_join = 25; end
				default: begin p_create = 25; p_exit = 25; p_join = 25; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < p_create)
				c = CMD_CREATE;
			else if (roll < p_create + p_exit)
				c = CMD_EXIT;
			else if (roll < p_create + p_exit + p_join)
				c = CMD_JOIN;
			else
				c = CMD_YIELD;
			if (n == DRAIN_ITEM) begin
				start <= 1'b0;
				drain();
			end
			issue(c, 4'($urandom_range(0, 15)),
				(n >= CALM_FIRST && n < CALM_LAST) ? 0 : draw_gap());
		end
		start <= 1'b0;

		// every beat in, then a little more than the longest command for stray beats
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// guard against a hung handshake, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: round_robin_thread_scheduler_unit.f
sv/rrts_pkg.sv
sv/rrts_ctrl.sv
sv/rrts_datapath.sv
sv/round_robin_thread_scheduler_unit.sv
tb/sv/sched_checker.sv
tb/sv/tb.sv
